// File: sv/lc4_pkg.sv
package lc4_pkg;

  localparam int GridSide    = 6;
  localparam int GridTiles   = GridSide * GridSide;
  localparam int TileW       = 6;
  localparam int PosW        = 3;
  localparam int KeyW        = 54;
  localparam int TilesPerReg = 9;
  localparam int NumKeyRegs  = 4;
  localparam int CfgIdxW     = 2;
  localparam int LutDepth    = 2 ** TileW;

  typedef logic [TileW-1:0] tile_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef tile_t [GridSide-1:0] row_t;
  typedef row_t  [GridSide-1:0] grid_t;
  typedef pos_t  [LutDepth-1:0] lut_t;

  typedef struct packed {
    pos_t row;
    pos_t col;
  } marker_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyA = 2'd0,
    CfgKeyB = 2'd1,
    CfgKeyC = 2'd2,
    CfgKeyD = 2'd3
  } cfg_reg_e;

  // row offset of a tile value: (v / 6) mod 6
  function automatic lut_t build_row_lut();
    lut_t l;
    for (int k = 0; k < LutDepth; k++) begin
      l[k] = pos_t'((k / GridSide) % GridSide);
    end
    return l;
  endfunction

  // column offset of a tile value: v mod 6
  function automatic lut_t build_col_lut();
    lut_t l;
    for (int k = 0; k < LutDepth; k++) begin
      l[k] = pos_t'(k % GridSide);
    end
    return l;
  endfunction

  localparam lut_t RowLut = build_row_lut();
  localparam lut_t ColLut = build_col_lut();

  // both operands below GridSide
  function automatic pos_t add_mod(pos_t a, pos_t b);
    logic [PosW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PosW+1)'(GridSide)) begin
      s = s - (PosW+1)'(GridSide);
    end
    return s[PosW-1:0];
  endfunction

  function automatic pos_t inc_mod(pos_t a);
    pos_t r;
    r = (a == pos_t'(GridSide - 1)) ? '0 : a + pos_t'(1);
    return r;
  endfunction

endpackage

// File: sv/lc4_stream_encrypt.sv
// LC4 (ElsieFour) stream encryption, one 6-bit tile symbol per request. The block takes
// a new symbol in every clock cycle while input ready is high; its ciphertext goes into
// the output buffer and the grid and marker update are registered on acceptance, since
// the next symbol starts from the state it leaves. A two-entry output buffer holds
// results while the consumer stalls, so input ready drops only once both entries are
// full. Load the four key registers (tiles 0-8, 9-17, 18-26, 27-35, six bits each,
// row-major) with a permutation of 0..35 and set message_start on the first symbol of
// each message to reload the grid and clear the marker.
module lc4_stream_encrypt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lc4_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lc4_pkg::KeyW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lc4_pkg::TileW-1:0]     plain_symbol_i,
  input  logic                          message_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lc4_pkg::TileW-1:0]     cipher_symbol_o
);

  logic [lc4_pkg::KeyW-1:0] key_q [lc4_pkg::NumKeyRegs];
  lc4_pkg::grid_t           key_grid;
  lc4_pkg::grid_t           grid_q, grid_d;
  lc4_pkg::marker_t         marker_q, marker_d;
  lc4_pkg::tile_t           cipher;
  logic                     in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lc4_pkg::NumKeyRegs; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (lc4_pkg::cfg_reg_e'(cfg_index_i))
        lc4_pkg::CfgKeyA: key_q[lc4_pkg::CfgKeyA] <= cfg_data_i;
        lc4_pkg::CfgKeyB: key_q[lc4_pkg::CfgKeyB] <= cfg_data_i;
        lc4_pkg::CfgKeyC: key_q[lc4_pkg::CfgKeyC] <= cfg_data_i;
        lc4_pkg::CfgKeyD: key_q[lc4_pkg::CfgKeyD] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < lc4_pkg::GridTiles; k++) begin
      key_grid[k / lc4_pkg::GridSide][k % lc4_pkg::GridSide] =
        key_q[k / lc4_pkg::TilesPerReg][lc4_pkg::TileW * (k % lc4_pkg::TilesPerReg) +:
                                        lc4_pkg::TileW];
    end
  end

  lc4_step u_step (
    .grid_i          (grid_q),
    .key_grid_i      (key_grid),
    .marker_i        (marker_q),
    .plain_symbol_i  (plain_symbol_i),
    .message_start_i (message_start_i),
    .cipher_symbol_o (cipher),
    .grid_o          (grid_d),
    .marker_o        (marker_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q   <= '0;
      marker_q <= '0;
    end else if (in_accept) begin
      grid_q   <= grid_d;
      marker_q <= marker_d;
    end
  end

  lc4_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (cipher),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (cipher_symbol_o)
  );

  a_marker_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (marker_q.row < lc4_pkg::pos_t'(lc4_pkg::GridSide)) &&
    (marker_q.col < lc4_pkg::pos_t'(lc4_pkg::GridSide)))
    else $error("marker left the grid");

  a_state_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> ($stable(grid_q) && $stable(marker_q)))
    else $error("grid or marker changed without a request");

endmodule

// File: sv/lc4_step.sv
module lc4_step (
  input  lc4_pkg::grid_t   grid_i,
  input  lc4_pkg::grid_t   key_grid_i,
  input  lc4_pkg::marker_t marker_i,
  input  lc4_pkg::tile_t   plain_symbol_i,
  input  logic             message_start_i,
  output lc4_pkg::tile_t   cipher_symbol_o,
  output lc4_pkg::grid_t   grid_o,
  output lc4_pkg::marker_t marker_o
);

  lc4_pkg::grid_t   g;
  lc4_pkg::grid_t   g_row;
  lc4_pkg::marker_t mk;
  lc4_pkg::pos_t    r;
  lc4_pkg::pos_t    c;
  lc4_pkg::pos_t    x;
  lc4_pkg::pos_t    y;
  lc4_pkg::pos_t    y_rot;
  lc4_pkg::pos_t    mcol_rot;
  lc4_pkg::pos_t    mrow_rot;
  lc4_pkg::tile_t   m;
  lc4_pkg::tile_t   ct;

  assign g  = message_start_i ? key_grid_i : grid_i;
  assign mk = message_start_i ? '0 : marker_i;

  // first match in row-major order wins, no match falls back to the corner
  always_comb begin
    r = '0;
    c = '0;
    for (int i = lc4_pkg::GridSide - 1; i >= 0; i--) begin
      for (int j = lc4_pkg::GridSide - 1; j >= 0; j--) begin
        if (g[i][j] == plain_symbol_i) begin
          r = lc4_pkg::pos_t'(i);
          c = lc4_pkg::pos_t'(j);
        end
      end
    end
  end

  assign m  = g[mk.row][mk.col];
  assign x  = lc4_pkg::add_mod(r, lc4_pkg::RowLut[m]);
  assign y  = lc4_pkg::add_mod(c, lc4_pkg::ColLut[m]);
  assign ct = g[x][y];

  // plaintext row rotates right
  always_comb begin
    for (int i = 0; i < lc4_pkg::GridSide; i++) begin
      for (int j = 0; j < lc4_pkg::GridSide; j++) begin
        if (lc4_pkg::pos_t'(i) == r) begin
          g_row[i][j] = g[i][(j + lc4_pkg::GridSide - 1) % lc4_pkg::GridSide];
        end else begin
          g_row[i][j] = g[i][j];
        end
      end
    end
  end

  // marker and cipher position follow the row rotation
  assign mcol_rot = (mk.row == r) ? lc4_pkg::inc_mod(mk.col) : mk.col;
  assign y_rot    = (x == r) ? lc4_pkg::inc_mod(y) : y;

  // ciphertext column rotates down
  always_comb begin
    for (int i = 0; i < lc4_pkg::GridSide; i++) begin
      for (int j = 0; j < lc4_pkg::GridSide; j++) begin
        if (lc4_pkg::pos_t'(j) == y_rot) begin
          grid_o[i][j] = g_row[(i + lc4_pkg::GridSide - 1) % lc4_pkg::GridSide][j];
        end else begin
          grid_o[i][j] = g_row[i][j];
        end
      end
    end
  end

  assign mrow_rot = (mcol_rot == y_rot) ? lc4_pkg::inc_mod(mk.row) : mk.row;

  assign marker_o.row    = lc4_pkg::add_mod(mrow_rot, lc4_pkg::RowLut[ct]);
  assign marker_o.col    = lc4_pkg::add_mod(mcol_rot, lc4_pkg::ColLut[ct]);
  assign cipher_symbol_o = ct;

endmodule

// File: sv/lc4_out_buf.sv
module lc4_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lc4_pkg::tile_t push_data_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lc4_pkg::tile_t out_data_o
);

  logic           main_v_q, main_v_d;
  logic           skid_v_q, skid_v_d;
  lc4_pkg::tile_t main_q, main_d;
  lc4_pkg::tile_t skid_q, skid_d;
  logic           pop;

  assign pop     = main_v_q && out_ready_i;
  assign ready_o = !skid_v_q;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = push_i;
        skid_d   = push_data_i;
      end else begin
        main_v_d = push_i;
        main_d   = push_data_i;
      end
    end else if (push_i) begin
      if (!main_v_q) begin
        main_v_d = 1'b1;
        main_d   = push_data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without a head entry");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("request pushed into a full buffer");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && main_v_q && !out_ready_i) |=> (skid_v_q && skid_q == $past(push_data_i)))
    else $error("stalled request not caught by skid entry");

endmodule
